@@ design/rgc_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rgc_pkg
// Shared types and constants of the RGB to grey converter.
// -----------------------------------------------------------------------------
package rgc_pkg;

	typedef logic [7:0]  chan_t;
	typedef logic [15:0] grey_t;
	typedef logic [1:0]  method_t;

	// grey method codes; the unused code falls back to luminosity
	localparam method_t METHOD_LUM   = 2'd0;
	localparam method_t METHOD_AVG   = 2'd1;
	localparam method_t METHOD_LIGHT = 2'd2;

	// Q0.16 luminosity weights, sized to their products with an 8-bit channel
	localparam logic [21:0] LUM_COEF_R = 22'd13763;
	localparam logic [23:0] LUM_COEF_G = 24'd46531;
	localparam logic [20:0] LUM_COEF_B = 21'd4588;

	// floor(x/3) = (x*683) >> 11 for x up to 765
	localparam logic [9:0] AVG_RECIP = 10'd683;
	localparam int         AVG_SHIFT = 11;

	// floor(256*k/3) for remainders one and two
	localparam chan_t AVG_FRAC_1 = 8'd85;
	localparam chan_t AVG_FRAC_2 = 8'd170;

	localparam grey_t GREY_FULL_SCALE = 16'hFF00;

	// registered input item
	typedef struct packed {
		chan_t   red;
		chan_t   green;
		chan_t   blue;
		logic    first;
		method_t method;
	} pix_item_t;

	// weighted products and channel sum/extremes
	typedef struct packed {
		logic [21:0] prod_r;
		logic [23:0] prod_g;
		logic [20:0] prod_b;
		logic [9:0]  sum;
		chan_t       hi;
		chan_t       lo;
		method_t     method;
		logic        first;
	} prod_item_t;

	// grey level on its way to the extrema stage
	typedef struct packed {
		grey_t grey;
		logic  first;
	} grey_item_t;

	// result item
	typedef struct packed {
		grey_t grey;
		grey_t min;
		grey_t max;
	} res_item_t;

endpackage : rgc_pkg
`default_nettype wire

@@ design/rgc_if.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rgc_if
// Valid/ready channels of the RGB to grey converter: pixel in, result out and
// the method register write.
// -----------------------------------------------------------------------------
interface rgc_pix_if import rgc_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic  first_of_image;

	modport source (output valid, red, green, blue, first_of_image, input ready);
	modport sink   (input valid, red, green, blue, first_of_image, output ready);
endinterface : rgc_pix_if

interface rgc_res_if import rgc_pkg::*; ();
	logic  valid;
	logic  ready;
	grey_t grey_level;
	grey_t image_min;
	grey_t image_max;

	modport source (output valid, grey_level, image_min, image_max, input ready);
	modport sink   (input valid, grey_level, image_min, image_max, output ready);
endinterface : rgc_res_if

interface rgc_cfg_if import rgc_pkg::*; ();
	logic    valid;
	logic    ready;
	method_t grey_method;

	modport source (output valid, grey_method, input ready);
	modport sink   (input valid, grey_method, output ready);
endinterface : rgc_cfg_if
`default_nettype wire

@@ design/rgc_grey_unit.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rgc_grey_unit
// Two pipeline stages: weighted products and channel sum/extremes, then the
// grey level of the selected method.
// -----------------------------------------------------------------------------
module rgc_grey_unit import rgc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire pix_item_t  in_item,
	output logic            in_ready,
	output logic            out_valid,
	output grey_item_t      out_item,
	input  wire logic       out_ready
);

	logic       v_s2;
	prod_item_t item_s2;
	logic       en_s2;
	prod_item_t prod_d;

	logic       v_s3;
	grey_item_t item_s3;
	logic       en_s3;

	logic [23:0] lum_sum;
	logic [19:0] avg_prod;
	chan_t       avg_quot;
	logic [9:0]  avg_rem;
	chan_t       avg_frac;
	logic [8:0]  light_sum;
	grey_t       grey_d;

	// stage 2: products, sum, max and min
	always_comb begin
		prod_d.prod_r = LUM_COEF_R * 22'(in_item.red);
		prod_d.prod_g = LUM_COEF_G * 24'(in_item.green);
		prod_d.prod_b = LUM_COEF_B * 21'(in_item.blue);
		prod_d.sum    = 10'(in_item.red) + 10'(in_item.green) + 10'(in_item.blue);
		prod_d.hi     = (in_item.red > in_item.green) ? in_item.red : in_item.green;
		if (in_item.blue > prod_d.hi) begin
			prod_d.hi = in_item.blue;
		end
		prod_d.lo     = (in_item.red < in_item.green) ? in_item.red : in_item.green;
		if (in_item.blue < prod_d.lo) begin
			prod_d.lo = in_item.blue;
		end
		prod_d.method = in_item.method;
		prod_d.first  = in_item.first;
	end

	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			item_s2 <= prod_d;
		end
	end

	// stage 3: pick the method
	always_comb begin
		lum_sum   = 24'(item_s2.prod_r) + item_s2.prod_g + 24'(item_s2.prod_b);
		avg_prod  = 20'(item_s2.sum) * 20'(AVG_RECIP);
		avg_quot  = avg_prod[AVG_SHIFT +: 8];
		avg_rem   = item_s2.sum - ({2'b00, avg_quot} + {1'b0, avg_quot, 1'b0});
		case (avg_rem[1:0])
			2'd1:    avg_frac = AVG_FRAC_1;
			2'd2:    avg_frac = AVG_FRAC_2;
			default: avg_frac = 8'd0;
		endcase
		light_sum = 9'(item_s2.hi) + 9'(item_s2.lo);
		case (item_s2.method)
			METHOD_AVG:   grey_d = {avg_quot, avg_frac};
			METHOD_LIGHT: grey_d = {light_sum, 7'd0};
			default:      grey_d = lum_sum[23:8];
		endcase
	end

	assign en_s3 = !v_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			item_s3.grey  <= grey_d;
			item_s3.first <= item_s2.first;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

`ifndef SYNTHESIS
	// a stalled stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_ready |=> v_s3 && $stable(item_s3))
		else $error("grey stage lost a stalled item");

	// lightness is a multiple of one half
	a_light_half: assert property (@(posedge clk) disable iff (!arst_n)
		en_s3 && v_s2 && item_s2.method == METHOD_LIGHT |=> item_s3.grey[6:0] == 7'd0)
		else $error("lightness result not a multiple of 0.5");

	// average never exceeds full scale
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		en_s3 && v_s2 && item_s2.method == METHOD_AVG |=> item_s3.grey <= GREY_FULL_SCALE)
		else $error("average above full scale");
`endif

endmodule : rgc_grey_unit
`default_nettype wire

@@ design/rgc_extrema.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rgc_extrema
// Result register; its min and max fields are the running extremes of the
// current image.
// -----------------------------------------------------------------------------
module rgc_extrema import rgc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire grey_item_t in_item,
	output logic            in_ready,
	output logic            out_valid,
	output res_item_t       out_item,
	input  wire logic       out_ready
);

	logic  valid_q;
	grey_t grey_q;
	grey_t min_q;
	grey_t max_q;
	logic  load;
	grey_t min_d;
	grey_t max_d;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_ready && in_valid;

	always_comb begin
		if (in_item.first) begin
			min_d = in_item.grey;
			max_d = in_item.grey;
		end else begin
			min_d = (in_item.grey < min_q) ? in_item.grey : min_q;
			max_d = (in_item.grey > max_q) ? in_item.grey : max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			min_q   <= GREY_FULL_SCALE;
			max_q   <= 16'd0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (load) begin
				min_q <= min_d;
				max_q <= max_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grey_q <= in_item.grey;
		end
	end

	assign out_valid     = valid_q;
	assign out_item.grey = grey_q;
	assign out_item.min  = min_q;
	assign out_item.max  = max_q;

`ifndef SYNTHESIS
	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> min_q <= grey_q && grey_q <= max_q)
		else $error("grey level outside running extremes");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load && in_item.first |=> min_q == grey_q && max_q == grey_q)
		else $error("first item did not restart extremes");

	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		load && !in_item.first |=> min_q <= $past(min_q) && max_q >= $past(max_q))
		else $error("running extremes moved the wrong way");
`endif

endmodule : rgc_extrema
`default_nettype wire

@@ design/rgb_to_grey_converter_core.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// rgb_to_grey_converter_core
// RGB pixel to Q8.8 grey level, with running image minimum and maximum.
// -----------------------------------------------------------------------------
// One pixel is taken per clock while the pipeline is not stalled, and its result
// passes the input register, product stage, method stage and result
// register; the four registers stall independently, so empty stages fill
// while the result side is held. The method register is sampled with each
// pixel: 0 luminosity, 1 average, 2 lightness, 3 behaves as luminosity. After
// reset the running minimum is 255.0 and the maximum 0.0; each pixel widens
// them, and a pixel flagged as first of image restarts both at its own grey level.
module rgb_to_grey_converter_core import rgc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rgc_cfg_if.sink   cfg,
	rgc_pix_if.sink   pix,
	rgc_res_if.source res
);

	method_t    method_q;
	logic       v_s1;
	pix_item_t  item_s1;
	logic       en_s1;
	logic       gu_in_ready;
	logic       gu_out_valid;
	grey_item_t gu_out_item;
	logic       ex_in_ready;
	res_item_t  ex_out_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_LUM;
		end else if (cfg.valid) begin
			method_q <= cfg.grey_method;
		end
	end

	assign en_s1     = !v_s1 || gu_in_ready;
	assign pix.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pix.valid) begin
			item_s1.red    <= pix.red;
			item_s1.green  <= pix.green;
			item_s1.blue   <= pix.blue;
			item_s1.first  <= pix.first_of_image;
			item_s1.method <= method_q;
		end
	end

	rgc_grey_unit u_grey (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_item   (item_s1),
		.in_ready  (gu_in_ready),
		.out_valid (gu_out_valid),
		.out_item  (gu_out_item),
		.out_ready (ex_in_ready)
	);

	rgc_extrema u_extrema (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (gu_out_valid),
		.in_item   (gu_out_item),
		.in_ready  (ex_in_ready),
		.out_valid (res.valid),
		.out_item  (ex_out_item),
		.out_ready (res.ready)
	);

	assign res.grey_level = ex_out_item.grey;
	assign res.image_min  = ex_out_item.min;
	assign res.image_max  = ex_out_item.max;

endmodule : rgb_to_grey_converter_core
`default_nettype wire
